// ----- rtl/core/assert_macros.svh -----
// assertion macros included by the level ramp rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// condition must never be true at a clock edge out of reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ----- rtl/core/blr_pkg.sv -----
// shared types and constants of the backlight level ramp
package blr_pkg;

   localparam int LEVEL_BITS_DEF = 16;
   localparam int FIELD_W        = 16;
   localparam int TICK_W         = 10;
   localparam int CSR_ADDR_W     = 2;

   localparam logic [FIELD_W-1:0] MAX_LEVEL_RST  = 16'd255;
   localparam logic [FIELD_W-1:0] FULL_SWEEP_RST = 16'd1000;
   localparam logic [TICK_W-1:0]  TICK_RST       = 10'd10;
   localparam logic [FIELD_W-1:0] MIN_RAMP_RST   = 16'd1000;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_SET    = 2'd1,
      OP_PRESET = 2'd2
   } opcode_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_MAX_LEVEL  = 2'd0,
      REG_FULL_SWEEP = 2'd1,
      REG_TICK       = 2'd2,
      REG_MIN_RAMP   = 2'd3
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAG_UP,
      ST_MAG_DN,
      ST_MUL,
      ST_HALF,
      ST_DIV_P,
      ST_CLAMP,
      ST_DIV_C,
      ST_SETUP_M,
      ST_DIV_M,
      ST_MOVE,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/core/backlight_level_ramp.sv -----
// backlight level ramp: target and level registers with an iterative step unit
//
//  channel   dir  handshake              payload
//  req       in   req_tvalid/req_tready  tuser: opcode, tdata: new_level
//  rsp       out  rsp_tvalid/rsp_tready  tdata: level, target, level_changed
//  csr       in   csr_we                 csr_addr, csr_wdata
//
// a tick or set transaction that moves the level has its result valid after
// a 16 step shift-add multiply and three restoring divides, all run on one
// shared adder; req_tready rises again in the same cycle that the result
// becomes valid
// preset and opcode 3 go straight to the final state, a level already on
// target goes there after the magnitude check
// synchronous reset clears control state and levels and loads the registers with their defaults
// req_tready is low while a transaction is being worked on; a finished result
// waits in the output register and holds the sequencer in its final state only
// when that register is still full
module backlight_level_ramp #(
   parameter int LEVEL_BITS = blr_pkg::LEVEL_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,   // new_level[15:0]
   input  logic [1:0]                    req_tuser,   // opcode[1:0]
   // result channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [39:0]                   rsp_tdata,   // level[15:0], target[31:16],
                                                      // level_changed[32], zero pad
   // register write port
   input  logic                          csr_we,
   input  logic [blr_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [blr_pkg::FIELD_W-1:0]   csr_wdata
);

   localparam int LB = LEVEL_BITS;
   localparam int FW = blr_pkg::FIELD_W;
   localparam int W  = LB + FW;          // product and quotient width
   localparam int AW = W + 1;            // adder width, holds a shifted remainder
   localparam int CW = $clog2(W + 1);

   // configuration registers
   logic [FW-1:0]              max_level_ff;
   logic [FW-1:0]              full_sweep_ff;
   logic [blr_pkg::TICK_W-1:0] tick_ff;
   logic [FW-1:0]              min_ramp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_level_ff  <= blr_pkg::MAX_LEVEL_RST;
         full_sweep_ff <= blr_pkg::FULL_SWEEP_RST;
         tick_ff       <= blr_pkg::TICK_RST;
         min_ramp_ff   <= blr_pkg::MIN_RAMP_RST;
      end else if (csr_we) begin
         case (csr_addr)
            blr_pkg::REG_MAX_LEVEL:  max_level_ff  <= csr_wdata;
            blr_pkg::REG_FULL_SWEEP: full_sweep_ff <= csr_wdata;
            blr_pkg::REG_TICK:       tick_ff       <= csr_wdata[blr_pkg::TICK_W-1:0];
            blr_pkg::REG_MIN_RAMP:   min_ramp_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // zero divisors count as one
   logic [FW-1:0]              max_div;
   logic [blr_pkg::TICK_W-1:0] tick_div;
   assign max_div  = (max_level_ff == '0) ? FW'(1) : max_level_ff;
   assign tick_div = (tick_ff == '0) ? blr_pkg::TICK_W'(1) : tick_ff;

   // sequencer and datapath registers
   blr_pkg::state_type state_ff, state_in;
   logic [LB-1:0] target_ff, target_in;
   logic [LB-1:0] current_ff, current_in;
   logic [LB-1:0] mag_ff, mag_in;
   logic          down_ff, down_in;
   logic          changed_ff, changed_in;
   logic [W-1:0]  acc_ff, acc_in;     // product, dividend shifting out, quotient in
   logic [W-1:0]  rem_ff, rem_in;     // divide remainder
   logic [W-1:0]  den_ff, den_in;     // divisor, later the step size
   logic [FW-1:0] fs_ff, fs_in;       // multiplier bits, msb first
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0] rsp_level_ff, rsp_level_in;
   logic [FW-1:0] rsp_target_ff, rsp_target_in;
   logic          rsp_changed_ff, rsp_changed_in;

   logic          req_accept;
   logic [LB-1:0] req_level;
   logic [AW-1:0] rem_sh;
   logic [LB-1:0] quot_lo;
   logic [LB-1:0] move_size;

   assign req_tready = (state_ff == blr_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_level  = LB'(req_tdata[FW-1:0]);
   assign rem_sh     = {rem_ff, acc_ff[W-1]};
   assign quot_lo    = acc_ff[LB-1:0];
   // a truncated step of zero still moves by one
   assign move_size  = (quot_lo == '0) ? LB'(1) : quot_lo;

   // shared adder and subtractor
   logic [AW-1:0] alu_a, alu_b;
   logic          alu_sub;
   logic [AW:0]   alu_sum;
   logic [AW-1:0] alu_res;
   logic          alu_borrow;

   assign alu_sum    = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                       + (AW+1)'(alu_sub);
   assign alu_res    = alu_sum[AW-1:0];
   assign alu_borrow = !alu_sum[AW];

   // operand selection for each step
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         blr_pkg::ST_MAG_UP: begin
            alu_a   = AW'(target_ff);
            alu_b   = AW'(current_ff);
            alu_sub = 1'b1;
         end
         blr_pkg::ST_MAG_DN: begin
            alu_a   = AW'(current_ff);
            alu_b   = AW'(target_ff);
            alu_sub = 1'b1;
         end
         blr_pkg::ST_MUL: begin
            alu_a = {acc_ff, 1'b0};
            alu_b = fs_ff[FW-1] ? AW'(mag_ff) : '0;
         end
         blr_pkg::ST_HALF: begin
            alu_a = AW'(acc_ff);
            alu_b = AW'(max_div >> 1);
         end
         blr_pkg::ST_DIV_P, blr_pkg::ST_DIV_C, blr_pkg::ST_DIV_M: begin
            alu_a   = rem_sh;
            alu_b   = AW'(den_ff);
            alu_sub = 1'b1;
         end
         blr_pkg::ST_CLAMP: begin
            alu_a   = AW'(acc_ff);
            alu_b   = AW'(min_ramp_ff);
            alu_sub = 1'b1;
         end
         blr_pkg::ST_MOVE: begin
            alu_a   = AW'(current_ff);
            alu_b   = AW'(den_ff);
            alu_sub = down_ff;
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in       = state_ff;
      target_in      = target_ff;
      current_in     = current_ff;
      mag_in         = mag_ff;
      down_in        = down_ff;
      changed_in     = changed_ff;
      acc_in         = acc_ff;
      rem_in         = rem_ff;
      den_in         = den_ff;
      fs_in          = fs_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_level_in   = rsp_level_ff;
      rsp_target_in  = rsp_target_ff;
      rsp_changed_in = rsp_changed_ff;

      case (state_ff)
         blr_pkg::ST_IDLE: begin
            if (req_accept) begin
               changed_in = 1'b0;
               case (req_tuser)
                  blr_pkg::OP_TICK: begin
                     state_in = blr_pkg::ST_MAG_UP;
                  end
                  blr_pkg::OP_SET: begin
                     // clamp to the highest level
                     if (W'(req_level) > W'(max_level_ff))
                        target_in = LB'(max_level_ff);
                     else
                        target_in = req_level;
                     state_in = blr_pkg::ST_MAG_UP;
                  end
                  blr_pkg::OP_PRESET: begin
                     target_in  = req_level;
                     current_in = req_level;
                     state_in   = blr_pkg::ST_DONE;
                  end
                  default: begin
                     state_in = blr_pkg::ST_DONE;
                  end
               endcase
            end
         end
         blr_pkg::ST_MAG_UP: begin
            if (alu_res == '0) begin
               state_in = blr_pkg::ST_DONE;
            end else if (alu_borrow) begin
               down_in  = 1'b1;
               state_in = blr_pkg::ST_MAG_DN;
            end else begin
               down_in  = 1'b0;
               mag_in   = alu_res[LB-1:0];
               acc_in   = '0;
               fs_in    = full_sweep_ff;
               cnt_in   = CW'(FW);
               state_in = blr_pkg::ST_MUL;
            end
         end
         blr_pkg::ST_MAG_DN: begin
            mag_in   = alu_res[LB-1:0];
            acc_in   = '0;
            fs_in    = full_sweep_ff;
            cnt_in   = CW'(FW);
            state_in = blr_pkg::ST_MUL;
         end
         blr_pkg::ST_MUL: begin
            acc_in = alu_res[W-1:0];
            fs_in  = {fs_ff[FW-2:0], 1'b0};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1))
               state_in = blr_pkg::ST_HALF;
         end
         blr_pkg::ST_HALF: begin
            // rounding term, then divide by the highest level
            acc_in   = alu_res[W-1:0];
            rem_in   = '0;
            den_in   = W'(max_div);
            cnt_in   = CW'(W);
            state_in = blr_pkg::ST_DIV_P;
         end
         blr_pkg::ST_DIV_P, blr_pkg::ST_DIV_C, blr_pkg::ST_DIV_M: begin
            if (alu_borrow) begin
               rem_in = rem_sh[W-1:0];
               acc_in = {acc_ff[W-2:0], 1'b0};
            end else begin
               rem_in = alu_res[W-1:0];
               acc_in = {acc_ff[W-2:0], 1'b1};
            end
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               case (state_ff)
                  blr_pkg::ST_DIV_P: state_in = blr_pkg::ST_CLAMP;
                  blr_pkg::ST_DIV_C: state_in = blr_pkg::ST_SETUP_M;
                  default:           state_in = blr_pkg::ST_MOVE;
               endcase
            end
         end
         blr_pkg::ST_CLAMP: begin
            // ramp time is at least the shortest ramp
            if (alu_borrow)
               acc_in = W'(min_ramp_ff);
            rem_in   = '0;
            den_in   = W'(tick_div);
            cnt_in   = CW'(W);
            state_in = blr_pkg::ST_DIV_C;
         end
         blr_pkg::ST_SETUP_M: begin
            // step count held at one or more, dividend aligned to the top
            den_in   = (acc_ff == '0) ? W'(1) : acc_ff;
            acc_in   = {mag_ff, {FW{1'b0}}};
            rem_in   = '0;
            cnt_in   = CW'(LB);
            state_in = blr_pkg::ST_DIV_M;
         end
         blr_pkg::ST_MOVE: begin
            // first cycle holds the quotient in acc; latch step then apply
            if (den_ff == W'(move_size) || cnt_ff != '0) begin
               current_in = alu_res[LB-1:0];
               changed_in = 1'b1;
               state_in   = blr_pkg::ST_DONE;
            end else begin
               den_in = W'(move_size);
               cnt_in = CW'(1);
            end
         end
         blr_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_level_in   = FW'(current_ff);
               rsp_target_in  = FW'(target_ff);
               rsp_changed_in = changed_ff;
               state_in       = blr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = blr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= blr_pkg::ST_IDLE;
         target_ff    <= '0;
         current_ff   <= '0;
         changed_ff   <= 1'b0;
         down_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         current_ff   <= current_in;
         changed_ff   <= changed_in;
         down_ff      <= down_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff         <= mag_in;
      acc_ff         <= acc_in;
      rem_ff         <= rem_in;
      den_ff         <= den_in;
      fs_ff          <= fs_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_target_ff  <= rsp_target_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_changed_ff, rsp_target_ff, rsp_level_ff};

`include "assert_macros.svh"

   // a waiting result is never dropped
   `ASSERT_PROP(a_rsp_held, clock, reset, (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff)
   // an accepted transaction always leaves idle
   `ASSERT_PROP(a_busy_after_accept, clock, reset, req_accept |=> (state_ff != blr_pkg::ST_IDLE))
   // a step never passes the target
   `ASSERT_PROP(a_no_overshoot, clock, reset,
      (state_ff == blr_pkg::ST_MOVE && state_in == blr_pkg::ST_DONE) |=>
      (down_ff ? (current_ff >= target_ff) : (current_ff <= target_ff)))
   // the applied step is never zero
   `ASSERT_NEVER(a_zero_step, clock, reset,
      state_ff == blr_pkg::ST_MOVE && state_in == blr_pkg::ST_DONE && den_ff == '0)

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the backlight level ramp: directed, extreme, back-pressure and random transactions
module testbench;

   // opcode 3 has no package name: the block must leave its state alone
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // long output hold-off used to fill the block and stall its input
   localparam int HOLD_OFF_CYCLES = 400;
   // settling time after the last result, longer than one stepped transaction
   localparam int SETTLE_CYCLES = 200;

   typedef struct packed {
      logic [15:0] level;
      logic [15:0] target;
      logic        changed;
   } level_report_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [15:0]                    req_tdata;   // new_level[15:0]
   logic [1:0]                     req_tuser;   // opcode[1:0]
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [39:0]                    rsp_tdata;   // level[15:0], target[31:16], level_changed[32], zero pad
   logic                           csr_we;
   logic [blr_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [blr_pkg::FIELD_W-1:0]    csr_wdata;

   // shadow copy of the registers, written only while the block is idle
   logic [15:0] shadow_max_level  = blr_pkg::MAX_LEVEL_RST;
   logic [15:0] shadow_full_sweep = blr_pkg::FULL_SWEEP_RST;
   logic [9:0]  shadow_tick       = blr_pkg::TICK_RST;
   logic [15:0] shadow_min_ramp   = blr_pkg::MIN_RAMP_RST;

   // predicted fader state
   logic [15:0] fader_target = '0;
   logic [15:0] fader_level  = '0;

   // reports still owed by the block, oldest first
   level_report_type owed_reports[$];
   level_report_type seen_report;
   level_report_type owed_report;

   int mismatch_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   bit hold_off_request = 1'b0;
   int hold_off_left = 0;

   backlight_level_ramp dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // one step of the level toward the target; returns 1 when the level moved
   function automatic bit step_toward_target();
      longint unsigned gap, divisor, tick, ramp_ms, steps, stride;
      bit downward;
      if (fader_level == fader_target) return 1'b0;
      downward = fader_target < fader_level;
      gap = downward ? fader_level - fader_target : fader_target - fader_level;
      // zero registers act as a divisor of one
      divisor = (shadow_max_level == 0) ? 1 : shadow_max_level;
      tick    = (shadow_tick == 0) ? 1 : shadow_tick;
      ramp_ms = (gap * shadow_full_sweep + divisor / 2) / divisor;
      if (ramp_ms < shadow_min_ramp) ramp_ms = shadow_min_ramp;
      steps = ramp_ms / tick;
      if (steps == 0) steps = 1;
      stride = gap / steps;
      if (stride == 0) stride = 1;
      // stride never exceeds the gap, so no overshoot and no wrap
      if (downward) fader_level = fader_level - stride[15:0];
      else fader_level = fader_level + stride[15:0];
      return 1'b1;
   endfunction

   // applies one request to the predicted state and returns the report it causes
   function automatic level_report_type fader_report(logic [1:0] op, logic [15:0] value);
      level_report_type report;
      report.changed = 1'b0;
      case (op)
         blr_pkg::OP_TICK: begin
            report.changed = step_toward_target();
         end
         blr_pkg::OP_SET: begin
            fader_target = (value > shadow_max_level) ? shadow_max_level : value;
            report.changed = step_toward_target();
         end
         blr_pkg::OP_PRESET: begin
            // start-up read: no clamp and no step
            fader_target = value;
            fader_level  = value;
         end
         default: ;
      endcase
      report.level  = fader_level;
      report.target = fader_target;
      return report;
   endfunction

   // offers one request transaction, with an optional idle gap in front of it;
   // returns on the falling edge after acceptance with tvalid still high
   task automatic send_request(input logic [1:0] op, input logic [15:0] value);
      int gap;
      gap = 0;
      if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct)
         gap = $urandom_range(1, 150);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      owed_reports.push_back(fader_report(op, value));
      @(negedge clock);
   endtask

   // sender pause until the block has returned every owed report
   task automatic wait_for_reports();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (owed_reports.size() != 0);
   endtask

   // writes all four registers back to back; block must be idle
   task automatic write_registers(input logic [15:0] max_level, input logic [15:0] full_sweep,
                                  input logic [9:0] tick, input logic [15:0] min_ramp);
      logic [15:0] values[4];
      values[0] = max_level;
      values[1] = full_sweep;
      values[2] = {6'd0, tick};
      values[3] = min_ramp;
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= blr_pkg::reg_index_type'(i);
         csr_wdata <= values[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      shadow_max_level  = max_level;
      shadow_full_sweep = full_sweep;
      shadow_tick       = tick;
      shadow_min_ramp   = min_ramp;
   endtask

   // register value: either end of the range or anything in between
   function automatic logic [15:0] pick_setting(int lo, int hi);
      case ($urandom_range(0, 3))
         0: return 16'(lo);
         1: return 16'(hi);
         default: return 16'($urandom_range(lo, hi));
      endcase
   endfunction

   // one well-formed ramp: optional preset, a new target, then a run of ticks
   task automatic send_ramp(output int count);
      logic [15:0] goal;
      int ticks;
      count = 0;
      if ($urandom_range(0, 2) == 0) begin
         send_request(blr_pkg::OP_PRESET, 16'($urandom));
         count++;
      end
      if ($urandom_range(0, 4) == 0) goal = 16'($urandom);
      else goal = 16'($urandom_range(0, shadow_max_level));
      send_request(blr_pkg::OP_SET, goal);
      count++;
      ticks = $urandom_range(1, 24);
      repeat (ticks) begin
         send_request(blr_pkg::OP_TICK, 16'($urandom));
         count++;
      end
   endtask

   // power-on register values: clamp, both directions, unused opcode, preset above max
   task automatic test_directed_defaults();
      send_request(blr_pkg::OP_TICK, 16'h0000);      // already on target
      send_request(blr_pkg::OP_SET, 16'hFFFF);       // clamped to max level
      send_request(blr_pkg::OP_TICK, 16'h5555);
      send_request(blr_pkg::OP_TICK, 16'hAAAA);
      send_request(OP_UNUSED, 16'hFFFF);             // no change at all
      send_request(blr_pkg::OP_SET, 16'h0000);       // ramp down
      send_request(blr_pkg::OP_PRESET, 16'hFFFF);    // preset bypasses the clamp
      send_request(blr_pkg::OP_TICK, 16'h0000);
      send_request(blr_pkg::OP_SET, 16'h00AA);       // long way down from full scale
      send_request(blr_pkg::OP_PRESET, 16'h0000);
      send_request(blr_pkg::OP_SET, 16'h0001);       // smallest possible move
      send_request(blr_pkg::OP_TICK, 16'h0000);
   endtask

   // zero and full-scale register values, and a target left above a lowered max
   task automatic test_register_extremes();
      // zero max level, zero tick and no lower bound on the ramp time
      wait_for_reports();
      write_registers(16'd0, 16'd1, 10'd0, 16'd0);
      send_request(blr_pkg::OP_PRESET, 16'd1000);
      send_request(blr_pkg::OP_SET, 16'h1234);       // clamps to zero
      send_request(blr_pkg::OP_TICK, 16'h0000);
      // short sweep over a wide range: whole gap in one step
      wait_for_reports();
      write_registers(16'hFFFF, 16'd1, 10'd1000, 16'd0);
      send_request(blr_pkg::OP_SET, 16'hFFFF);
      send_request(blr_pkg::OP_SET, 16'h0000);
      // slowest possible ramp
      wait_for_reports();
      write_registers(16'hFFFF, 16'hFFFF, 10'd1, 16'hFFFF);
      send_request(blr_pkg::OP_SET, 16'hFFFF);
      send_request(blr_pkg::OP_TICK, 16'h0000);
      // one-level range
      wait_for_reports();
      write_registers(16'd1, 16'd1, 10'd1000, 16'd1);
      send_request(blr_pkg::OP_SET, 16'hFFFF);
      send_request(blr_pkg::OP_TICK, 16'h0000);
      // lower max level under a stored target: steps keep heading for it
      wait_for_reports();
      write_registers(16'hFFFF, blr_pkg::FULL_SWEEP_RST, blr_pkg::TICK_RST,
                      blr_pkg::MIN_RAMP_RST);
      send_request(blr_pkg::OP_SET, 16'd40000);
      wait_for_reports();
      write_registers(16'd100, blr_pkg::FULL_SWEEP_RST, blr_pkg::TICK_RST,
                      blr_pkg::MIN_RAMP_RST);
      send_request(blr_pkg::OP_TICK, 16'h0000);
      send_request(blr_pkg::OP_TICK, 16'h0000);
   endtask

   // receiver holds off for a long stretch while ramps keep coming
   task automatic test_output_backpressure();
      int sent, count;
      wait_for_reports();
      write_registers(16'hFFFF, 16'd500, 10'd20, 16'd200);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_off_request   = 1'b1;
      sent = 0;
      while (sent < 40) begin
         send_ramp(count);
         sent += count;
      end
      wait_for_reports();
   endtask

   // random ramps and noise under changing registers and idle patterns
   task automatic test_random_ramps();
      int sent, count;
      bit paused;
      for (int phase = 0; phase < 6; phase++) begin
         wait_for_reports();
         write_registers(pick_setting(1, 65535), pick_setting(1, 65535),
                         10'(pick_setting(1, 1000)), pick_setting(1, 65535));
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 45; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 45; end
            default: begin sender_idle_pct = 32; receiver_stall_pct = 32; end
         endcase
         sent = 0;
         paused = 1'b0;
         while (sent < 205) begin
            // sender pause mid-phase until everything is back
            if (phase == 3 && !paused && sent >= 100) begin
               wait_for_reports();
               paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 8) begin
               send_ramp(count);
               sent += count;
            end else begin
               // noise: any opcode, any value
               repeat ($urandom_range(1, 4)) begin
                  send_request(2'($urandom_range(0, 3)), 16'($urandom));
                  sent++;
               end
            end
         end
      end
   endtask

   // receiver: random stalls, plus a counted hold-off on request
   always @(negedge clock) begin
      if (hold_off_request) begin
         hold_off_request = 1'b0;
         hold_off_left = HOLD_OFF_CYCLES;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // result checker: each result transaction against the oldest owed report
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_report.level   = rsp_tdata[15:0];
         seen_report.target  = rsp_tdata[31:16];
         seen_report.changed = rsp_tdata[32];
         if (owed_reports.size() == 0) begin
            $display("%0t: unexpected result level %0d target %0d changed %0b", $time,
                     seen_report.level, seen_report.target, seen_report.changed);
            mismatch_count++;
         end else begin
            owed_report = owed_reports.pop_front();
            if (seen_report.level !== owed_report.level) begin
               $display("%0t: level expected %0d actual %0d", $time,
                        owed_report.level, seen_report.level);
               mismatch_count++;
            end
            if (seen_report.target !== owed_report.target) begin
               $display("%0t: target expected %0d actual %0d", $time,
                        owed_report.target, seen_report.target);
               mismatch_count++;
            end
            if (seen_report.changed !== owed_report.changed) begin
               $display("%0t: level_changed expected %0b actual %0b", $time,
                        owed_report.changed, seen_report.changed);
               mismatch_count++;
            end
         end
      end
   end

   // run limit: far beyond the slowest correct run
   initial begin
      #20000000;
      $display("backlight_level_ramp verification failed");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_defaults();
      test_register_extremes();
      test_output_backpressure();
      test_random_ramps();
      wait_for_reports();
      // catch any stray result after the last owed one
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("backlight_level_ramp verification clean");
      end else begin
         $display("backlight_level_ramp verification failed");
      end
      $finish;
   end

endmodule
